>>> hw/rtl/periodic_job_scheduler_top_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef PERIODIC_JOB_SCHEDULER_TOP_DEFINES_SVH
`define PERIODIC_JOB_SCHEDULER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define PJS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PJS_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PJS_ASSERT(label, clk, rst_n, prop)
`define PJS_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> hw/rtl/pjs_pkg.sv
// Package: types, codes and constants of the periodic job scheduler.
`default_nettype none
package pjs_pkg;
    localparam int MaxJobs = 16;
    localparam int IdxW = $clog2(MaxJobs);
    localparam int CntW = $clog2(MaxJobs + 1);
    localparam logic [26:0] DayMs = 27'd86400000;
    localparam logic [7:0] DayWrap = 8'd255;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ADD = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [2:0] EV_ADD = 3'd0;
    localparam logic [2:0] EV_REMOVE = 3'd1;
    localparam logic [2:0] EV_CLEAR = 3'd2;
    localparam logic [2:0] EV_FIRE = 3'd3;
    localparam logic [2:0] EV_TICK = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    typedef struct packed {
        logic [1:0] cmd;
        logic [9:0] period_ms_part;
        logic [5:0] period_sec_part;
        logic [5:0] period_min_part;
        logic [4:0] period_hour_part;
        logic [7:0] target_id;
    } in_item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] job_id;
        logic [1:0] status;
        logic [4:0] job_count;
        logic [4:0] uptime_hours;
        logic [5:0] uptime_minutes;
        logic [5:0] uptime_seconds;
        logic [7:0] uptime_days;
        logic last;
    } out_item_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;        // capture input item
        logic tick_upd;    // advance uptime and timer
        logic clear;       // empty table
        logic walk_start;  // begin fire walk at entry 0
        logic walk_next;   // advance walk index
        logic div_start;   // start modulo of timer by current period
        logic shift_step;  // one shift step of insert/remove
        logic commit_add;  // write new job
        logic commit_rm;   // drop count after removal
        logic conv_start;  // start uptime conversion
        logic emit;        // load output register
        logic [2:0] ev;
        logic [1:0] st;
        logic use_id;
        logic is_last;
    } pjs_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic period_ok;   // period of the captured item is settled
        logic period_zero;
        logic full;
        logic empty;
        logic walk_more;   // walk index valid and period <= timer
        logic div_done;
        logic divides;
        logic shift_more;
        logic found;
        logic conv_done;
        logic out_busy;
    } pjs_stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/pjs_ctrl.sv
// Controller state machine of the periodic job scheduler.
`default_nettype none
`include "periodic_job_scheduler_top_defines.svh"
module pjs_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire logic [1:0] in_cmd,
    input  wire pjs_pkg::pjs_stat_t stat,
    output pjs_pkg::pjs_cmd_t cmd
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_DEC   = 11'b00000000010,
        S_WALK  = 11'b00000000100,
        S_DIV   = 11'b00000001000,
        S_SHIFT = 11'b00000010000,
        S_CONV  = 11'b00000100000,
        S_EMIT  = 11'b00001000000,
        S_TICK  = 11'b00010000000,
        S_ADD   = 11'b00100000000,
        S_RM    = 11'b01000000000,
        S_CLR   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] op_reg, op_next;
    // pending result after conversion
    logic [2:0] ev_reg, ev_next;
    logic [1:0] st_reg, st_next;
    logic use_id_reg, use_id_next, last_reg, last_next;
    logic fire_reg, fire_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= pjs_pkg::CMD_TICK;
            ev_reg <= pjs_pkg::EV_TICK;
            st_reg <= pjs_pkg::ST_OK;
            use_id_reg <= 1'b0;
            last_reg <= 1'b0;
            fire_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            ev_reg <= ev_next;
            st_reg <= st_next;
            use_id_reg <= use_id_next;
            last_reg <= last_next;
            fire_reg <= fire_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        ev_next = ev_reg;
        st_next = st_reg;
        use_id_next = use_id_reg;
        last_next = last_reg;
        fire_next = fire_reg;
        cmd = '0;
        cmd.ev = ev_reg;
        cmd.st = st_reg;
        cmd.use_id = use_id_reg;
        cmd.is_last = last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    op_next = in_cmd;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (op_reg)
                    pjs_pkg::CMD_TICK:
                    begin
                        cmd.tick_upd = 1'b1;
                        state_next = S_TICK;
                    end
                    pjs_pkg::CMD_ADD:
                    begin
                        ev_next = pjs_pkg::EV_ADD;
                        last_next = 1'b1;
                        fire_next = 1'b0;
                        // hold until the period sum has settled
                        if (!stat.period_ok)
                            state_next = S_DEC;
                        else if (stat.period_zero)
                        begin
                            st_next = pjs_pkg::ST_ZERO;
                            use_id_next = 1'b0;
                            cmd.conv_start = 1'b1;
                            state_next = S_CONV;
                        end
                        else if (stat.full)
                        begin
                            st_next = pjs_pkg::ST_FULL;
                            use_id_next = 1'b0;
                            cmd.conv_start = 1'b1;
                            state_next = S_CONV;
                        end
                        else
                        begin
                            st_next = pjs_pkg::ST_OK;
                            use_id_next = 1'b1;
                            state_next = S_ADD;
                        end
                    end
                    pjs_pkg::CMD_REMOVE:
                    begin
                        ev_next = pjs_pkg::EV_REMOVE;
                        last_next = 1'b1;
                        use_id_next = 1'b0;
                        fire_next = 1'b0;
                        state_next = S_RM;
                    end
                    pjs_pkg::CMD_CLEAR:
                    begin
                        cmd.clear = 1'b1;
                        ev_next = pjs_pkg::EV_CLEAR;
                        st_next = pjs_pkg::ST_OK;
                        last_next = 1'b1;
                        use_id_next = 1'b0;
                        fire_next = 1'b0;
                        state_next = S_CLR;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_CLR:
            begin
                cmd.conv_start = 1'b1;
                state_next = S_CONV;
            end
            S_TICK:
            begin
                cmd.walk_start = 1'b1;
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (stat.walk_more)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    ev_next = pjs_pkg::EV_TICK;
                    st_next = pjs_pkg::ST_OK;
                    use_id_next = 1'b0;
                    last_next = 1'b1;
                    fire_next = 1'b0;
                    cmd.conv_start = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    if (stat.divides)
                    begin
                        ev_next = pjs_pkg::EV_FIRE;
                        st_next = pjs_pkg::ST_OK;
                        use_id_next = 1'b1;
                        last_next = 1'b0;
                        fire_next = 1'b1;
                        cmd.conv_start = 1'b1;
                        state_next = S_CONV;
                    end
                    else
                    begin
                        cmd.walk_next = 1'b1;
                        state_next = S_WALK;
                    end
                end
            end
            S_ADD:
            begin
                if (stat.shift_more)
                    cmd.shift_step = 1'b1;
                else
                begin
                    cmd.commit_add = 1'b1;
                    cmd.conv_start = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_RM:
            begin
                if (!stat.found)
                begin
                    st_next = pjs_pkg::ST_NOT_FOUND;
                    cmd.conv_start = 1'b1;
                    state_next = S_CONV;
                end
                else if (stat.shift_more)
                    cmd.shift_step = 1'b1;
                else
                begin
                    st_next = pjs_pkg::ST_OK;
                    cmd.commit_rm = 1'b1;
                    cmd.conv_start = 1'b1;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                if (stat.conv_done && !stat.out_busy)
                begin
                    cmd.emit = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (fire_reg)
                begin
                    fire_next = 1'b0;
                    cmd.walk_next = 1'b1;
                    state_next = S_WALK;
                end
                else
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `PJS_ASSERT(a_ready_idle, clk, rst_n, in_ready |-> (state_reg == S_IDLE))
    `PJS_ASSERT(a_load_dec, clk, rst_n, cmd.load |=> (state_reg == S_DEC))
    `PJS_ASSERT(a_emit_conv, clk, rst_n, cmd.emit |-> (state_reg == S_CONV))
endmodule
`default_nettype wire

>>> hw/rtl/pjs_datapath.sv
// Datapath: job table, timers, serial modulo, uptime conversion, output register.
`default_nettype none
`include "periodic_job_scheduler_top_defines.svh"
module pjs_datapath (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire pjs_pkg::in_item_t in_item,
    input  wire pjs_pkg::pjs_cmd_t cmd,
    output pjs_pkg::pjs_stat_t stat,
    output logic out_valid,
    input  wire logic out_ready,
    output pjs_pkg::out_item_t out_item
);
    localparam int IW = pjs_pkg::IdxW;
    localparam int CW = pjs_pkg::CntW;

    logic [26:0] per_reg [pjs_pkg::MaxJobs];
    logic [7:0] id_reg [pjs_pkg::MaxJobs];
    logic [CW-1:0] held_reg, held_next;
    logic [7:0] next_id_reg;
    logic [31:0] timer_reg;
    logic [26:0] up_reg;
    logic [7:0] day_reg;
    pjs_pkg::in_item_t item_reg;

    // period of the captured item, built in two registered steps
    logic [26:0] pa_reg, pb_reg, period_reg;
    logic [1:0] pstep_reg;

    // walk / shift index; holds a count so it may equal MaxJobs
    logic [CW-1:0] idx_reg;
    logic [IW-1:0] idx_lo;
    logic [IW-1:0] held_m1;
    logic found_reg;

    // serial modulo: remainder over 32 quotient bits
    logic [27:0] rem_reg;
    logic [31:0] dividend_reg;
    logic [5:0] dcnt_reg;
    logic div_busy_reg;
    logic [27:0] rem_sh;

    // uptime conversion by repeated subtraction of hour/min/sec units
    logic [26:0] crem_reg;
    logic [4:0] ch_reg;
    logic [5:0] cm_reg, cs_reg;
    logic [1:0] cph_reg;
    logic conv_busy_reg;

    logic [26:0] up_inc;
    logic [7:0] day_inc;

    assign idx_lo = idx_reg[IW-1:0];
    assign held_m1 = IW'(held_reg - CW'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
    end

    // period = ms + 1000 s + 60000 m + 3600000 h
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pstep_reg <= 2'd0;
        else if (cmd.load)
            pstep_reg <= 2'd0;
        else if (pstep_reg != 2'd2)
            pstep_reg <= pstep_reg + 2'd1;
    end

    always_ff @(posedge clk)
    begin
        pa_reg <= 27'(item_reg.period_ms_part) + 27'(item_reg.period_sec_part) * 27'd1000;
        pb_reg <= 27'(item_reg.period_min_part) * 27'd60000
            + 27'(item_reg.period_hour_part) * 27'd3600000;
        period_reg <= pa_reg + pb_reg;
    end

    assign up_inc = (up_reg + 27'd1 >= pjs_pkg::DayMs) ? 27'd0 : up_reg + 27'd1;
    assign day_inc = (day_reg + 8'd1 == pjs_pkg::DayWrap) ? 8'd0 : day_reg + 8'd1;

    assign held_next = cmd.clear ? '0
        : cmd.commit_add ? held_reg + CW'(1)
        : cmd.commit_rm ? held_reg - CW'(1) : held_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            next_id_reg <= 8'd1;
            timer_reg <= '0;
            up_reg <= '0;
            day_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
            if (cmd.commit_add)
                next_id_reg <= next_id_reg + 8'd1;
            if (cmd.tick_upd)
            begin
                timer_reg <= timer_reg + 32'd1;
                up_reg <= up_inc;
                if (up_reg + 27'd1 >= pjs_pkg::DayMs)
                    day_reg <= day_inc;
            end
            else if (cmd.walk_start && held_reg != '0
                     && timer_reg >= 32'(per_reg[0])
                     && timer_reg > 32'(per_reg[held_m1]))
                timer_reg <= 32'd1;
        end
    end

    // Walk index. For add it starts at the top and moves down while the
    // entry below has a period not below the new one. For remove it
    // first scans up for the id, then shifts down.
    logic ins_more;
    logic rm_scan;
    assign ins_more = (idx_reg != '0)
        && (per_reg[IW'(idx_reg - CW'(1))] >= period_reg);
    assign rm_scan = !found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            found_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg <= (in_item.cmd == pjs_pkg::CMD_ADD) ? held_reg : '0;
            found_reg <= 1'b0;
        end
        else if (cmd.walk_start)
            idx_reg <= '0;
        else if (cmd.walk_next)
            idx_reg <= idx_reg + CW'(1);
        else if (cmd.shift_step)
        begin
            if (item_reg.cmd == pjs_pkg::CMD_ADD)
                idx_reg <= idx_reg - CW'(1);
            else if (rm_scan)
            begin
                if (idx_reg < held_reg && id_reg[idx_lo] == item_reg.target_id)
                    found_reg <= 1'b1;
                else
                    idx_reg <= idx_reg + CW'(1);
            end
            else
                idx_reg <= idx_reg + CW'(1);
        end
    end

    // Table moves: one entry per step.
    always_ff @(posedge clk)
    begin
        if (cmd.shift_step && item_reg.cmd == pjs_pkg::CMD_ADD)
        begin
            per_reg[idx_lo] <= per_reg[IW'(idx_reg - CW'(1))];
            id_reg[idx_lo] <= id_reg[IW'(idx_reg - CW'(1))];
        end
        else if (cmd.shift_step && !rm_scan && idx_reg + CW'(1) < held_reg)
        begin
            per_reg[idx_lo] <= per_reg[IW'(idx_reg + CW'(1))];
            id_reg[idx_lo] <= id_reg[IW'(idx_reg + CW'(1))];
        end
        else if (cmd.commit_add)
        begin
            per_reg[idx_lo] <= period_reg;
            id_reg[idx_lo] <= next_id_reg;
        end
    end

    // Serial restoring modulo, one quotient bit per cycle.
    assign rem_sh = {rem_reg[26:0], dividend_reg[31]};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            dcnt_reg <= 6'd32;
        end
        else if (div_busy_reg)
        begin
            dcnt_reg <= dcnt_reg - 6'd1;
            if (dcnt_reg == 6'd1)
                div_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dividend_reg <= timer_reg;
        end
        else if (div_busy_reg)
        begin
            dividend_reg <= {dividend_reg[30:0], 1'b0};
            if (rem_sh >= {1'b0, per_reg[idx_lo]})
                rem_reg <= rem_sh - {1'b0, per_reg[idx_lo]};
            else
                rem_reg <= rem_sh;
        end
    end

    // Uptime to h/m/s by subtracting units, one per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conv_busy_reg <= 1'b0;
            cph_reg <= 2'd0;
        end
        else if (cmd.conv_start)
        begin
            conv_busy_reg <= 1'b1;
            cph_reg <= 2'd0;
        end
        else if (conv_busy_reg)
        begin
            unique case (cph_reg)
                2'd0: if (crem_reg < 27'd3600000) cph_reg <= 2'd1;
                2'd1: if (crem_reg < 27'd60000) cph_reg <= 2'd2;
                2'd2: if (crem_reg < 27'd1000) conv_busy_reg <= 1'b0;
                default: conv_busy_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.conv_start)
        begin
            crem_reg <= up_reg;
            ch_reg <= '0;
            cm_reg <= '0;
            cs_reg <= '0;
        end
        else if (conv_busy_reg)
        begin
            unique case (cph_reg)
                2'd0:
                    if (crem_reg >= 27'd3600000)
                    begin
                        crem_reg <= crem_reg - 27'd3600000;
                        ch_reg <= ch_reg + 5'd1;
                    end
                2'd1:
                    if (crem_reg >= 27'd60000)
                    begin
                        crem_reg <= crem_reg - 27'd60000;
                        cm_reg <= cm_reg + 6'd1;
                    end
                2'd2:
                    if (crem_reg >= 27'd1000)
                    begin
                        crem_reg <= crem_reg - 27'd1000;
                        cs_reg <= cs_reg + 6'd1;
                    end
                default: crem_reg <= crem_reg;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (cmd.emit)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item.event_res <= cmd.ev;
            out_item.job_id <= cmd.use_id
                ? ((cmd.ev == pjs_pkg::EV_ADD) ? next_id_reg - 8'd1 : id_reg[idx_lo])
                : 8'd0;
            out_item.status <= cmd.st;
            out_item.job_count <= 5'(held_reg);
            out_item.uptime_hours <= ch_reg;
            out_item.uptime_minutes <= cm_reg;
            out_item.uptime_seconds <= cs_reg;
            out_item.uptime_days <= day_reg;
            out_item.last <= cmd.is_last;
        end
    end

    always_comb
    begin
        stat = '0;
        stat.period_ok = (pstep_reg == 2'd2);
        stat.period_zero = (period_reg == '0);
        stat.full = (held_reg >= CW'(pjs_pkg::MaxJobs));
        stat.empty = (held_reg == '0);
        stat.walk_more = (idx_reg < held_reg) && (32'(per_reg[idx_lo]) <= timer_reg);
        stat.div_done = !div_busy_reg && !cmd.div_start;
        stat.divides = (rem_reg == '0);
        stat.shift_more = (item_reg.cmd == pjs_pkg::CMD_ADD) ? ins_more
            : (rm_scan ? 1'b1 : (idx_reg + CW'(1) < held_reg));
        stat.found = found_reg || (idx_reg < held_reg);
        stat.conv_done = !conv_busy_reg && !cmd.conv_start;
        stat.out_busy = out_valid && !out_ready;
    end

    `PJS_ASSERT(a_held_max, clk, rst_n, held_reg <= CW'(pjs_pkg::MaxJobs))
    `PJS_ASSERT(a_emit_free, clk, rst_n, cmd.emit |-> !(out_valid && !out_ready))
    `PJS_ASSERT(a_add_room, clk, rst_n, cmd.commit_add |-> held_reg < CW'(pjs_pkg::MaxJobs))
endmodule
`default_nettype wire

>>> hw/rtl/periodic_job_scheduler_top.sv
// Top level of the periodic job scheduler.
// Usage:
//   Input channel in_valid/in_ready carries one command item (tick, add,
//   remove, clear). in_ready is high only while the block is idle: one
//   item is processed at a time.
//   Output channel out_valid/out_ready carries result items; the final
//   result of an item has last set. A tick gives one fire result per job
//   whose period divides the execution timer, then a tick-done result.
//   Processing: add and remove move table entries one per step, and every
//   result waits for the uptime conversion (repeated unit subtraction). A
//   tick also runs the serial modulo once per visited job; the serial
//   modulo and the conversion unit dominate the processing time.
//   Reset empties the table, sets the next id to 1 and clears the timers.
//   A stalled receiver holds the output register; the controller waits
//   before loading the next result, so nothing is lost.
`default_nettype none
module periodic_job_scheduler_top (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire pjs_pkg::in_item_t in_data,
    output logic out_valid,
    input  wire logic out_ready,
    output pjs_pkg::out_item_t out_data
);
    pjs_pkg::pjs_cmd_t cmd;
    pjs_pkg::pjs_stat_t stat;

    pjs_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .in_cmd(in_data.cmd), .stat(stat), .cmd(cmd)
    );

    pjs_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_data), .cmd(cmd), .stat(stat),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_data)
    );
endmodule
`default_nettype wire

>>> tb/periodic_job_scheduler_checker.sv
// Checker for the periodic job scheduler: predicts result items and compares them.
`timescale 1ns / 1ps
`default_nettype none
module periodic_job_scheduler_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire pjs_pkg::in_item_t  in_data,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire pjs_pkg::out_item_t out_data,
    output int                      errors,
    output int                      pending
);
    logic [26:0]        job_period [pjs_pkg::MaxJobs];
    logic [7:0]         job_ident [pjs_pkg::MaxJobs];
    int                 jobs_in_table;
    logic [7:0]         id_next;
    logic [31:0]        fire_timer;
    logic [26:0]        ms_of_day;
    logic [7:0]         days_up;
    pjs_pkg::out_item_t expected_results [$];

    assign pending = expected_results.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Queue one result, stamped with the current count and uptime.
    task automatic push_result(input logic [2:0] ev, input logic [7:0] id,
                               input logic [1:0] st);
        pjs_pkg::out_item_t r;
        int unsigned rest;
        r.event_res      = ev;
        r.job_id         = id;
        r.status         = st;
        r.job_count      = 5'(jobs_in_table);
        r.uptime_hours   = 5'(ms_of_day / 3600000);
        rest             = ms_of_day % 3600000;
        r.uptime_minutes = 6'(rest / 60000);
        r.uptime_seconds = 6'((rest % 60000) / 1000);
        r.uptime_days    = days_up;
        r.last           = 1'b0;
        expected_results.push_back(r);
    endtask

    task automatic predict_schedule(input pjs_pkg::in_item_t it);
        logic [26:0] new_period;
        int pos;
        bit hit;
        case (it.cmd)
            pjs_pkg::CMD_TICK:
            begin
                ms_of_day  = ms_of_day + 1;
                fire_timer = fire_timer + 1;
                if (ms_of_day >= pjs_pkg::DayMs)
                begin
                    ms_of_day = 0;
                    days_up   = days_up + 1;
                    if (days_up == pjs_pkg::DayWrap) days_up = 0;
                end
                if (jobs_in_table > 0 && fire_timer >= 32'(job_period[0]))
                begin
                    if (fire_timer > 32'(job_period[jobs_in_table-1])) fire_timer = 1;
                    for (int i = 0; i < jobs_in_table; i++)
                    begin
                        if (32'(job_period[i]) > fire_timer) break;
                        if (job_period[i] != 0 && fire_timer % 32'(job_period[i]) == 0)
                            push_result(pjs_pkg::EV_FIRE, job_ident[i], pjs_pkg::ST_OK);
                    end
                end
                push_result(pjs_pkg::EV_TICK, 8'd0, pjs_pkg::ST_OK);
            end
            pjs_pkg::CMD_ADD:
            begin
                new_period = 27'(it.period_ms_part) + 27'(it.period_sec_part) * 27'd1000
                           + 27'(it.period_min_part) * 27'd60000
                           + 27'(it.period_hour_part) * 27'd3600000;
                if (new_period == 0)
                    push_result(pjs_pkg::EV_ADD, 8'd0, pjs_pkg::ST_ZERO);
                else if (jobs_in_table >= pjs_pkg::MaxJobs)
                    push_result(pjs_pkg::EV_ADD, 8'd0, pjs_pkg::ST_FULL);
                else
                begin
                    // newer job goes before older jobs of equal period
                    pos = 0;
                    while (pos < jobs_in_table && job_period[pos] < new_period) pos++;
                    for (int j = jobs_in_table; j > pos; j--)
                    begin
                        job_period[j] = job_period[j-1];
                        job_ident[j]  = job_ident[j-1];
                    end
                    job_period[pos] = new_period;
                    job_ident[pos]  = id_next;
                    jobs_in_table++;
                    push_result(pjs_pkg::EV_ADD, id_next, pjs_pkg::ST_OK);
                    id_next = id_next + 1;
                end
            end
            pjs_pkg::CMD_REMOVE:
            begin
                hit = 0;
                for (int i = 0; i < jobs_in_table && !hit; i++)
                begin
                    if (job_ident[i] == it.target_id)
                    begin
                        hit = 1;
                        for (int j = i; j + 1 < jobs_in_table; j++)
                        begin
                            job_period[j] = job_period[j+1];
                            job_ident[j]  = job_ident[j+1];
                        end
                        jobs_in_table--;
                    end
                end
                push_result(pjs_pkg::EV_REMOVE, 8'd0,
                            hit ? pjs_pkg::ST_OK : pjs_pkg::ST_NOT_FOUND);
            end
            default:
            begin
                jobs_in_table = 0;
                push_result(pjs_pkg::EV_CLEAR, 8'd0, pjs_pkg::ST_OK);
            end
        endcase
        expected_results[$].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pjs_pkg::out_item_t want;
        if (!rst_n)
        begin
            jobs_in_table = 0;
            id_next       = 8'd1;
            fire_timer    = '0;
            ms_of_day     = '0;
            days_up       = '0;
            errors        = 0;
            expected_results.delete();
        end
        else
        begin
            if (in_valid && in_ready) predict_schedule(in_data);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result item, queue size", 1, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (out_data.event_res != want.event_res)
                        report_mismatch("event_res", out_data.event_res, want.event_res);
                    if (out_data.job_id != want.job_id)
                        report_mismatch("job_id", out_data.job_id, want.job_id);
                    if (out_data.status != want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.job_count != want.job_count)
                        report_mismatch("job_count", out_data.job_count, want.job_count);
                    if (out_data.uptime_hours != want.uptime_hours)
                        report_mismatch("uptime_hours", out_data.uptime_hours,
                                        want.uptime_hours);
                    if (out_data.uptime_minutes != want.uptime_minutes)
                        report_mismatch("uptime_minutes", out_data.uptime_minutes,
                                        want.uptime_minutes);
                    if (out_data.uptime_seconds != want.uptime_seconds)
                        report_mismatch("uptime_seconds", out_data.uptime_seconds,
                                        want.uptime_seconds);
                    if (out_data.uptime_days != want.uptime_days)
                        report_mismatch("uptime_days", out_data.uptime_days, want.uptime_days);
                    if (out_data.last != want.last)
                        report_mismatch("last", out_data.last, want.last);
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_periodic_job_scheduler_top.sv
// Testbench top for the periodic job scheduler: stimulus, stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_periodic_job_scheduler_top;
    // The limit leaves a wide margin for the worst ticks over 250+ items.
    localparam int CycleLimit = 4000000;
    localparam int DrainCycles = 3000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    pjs_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    pjs_pkg::out_item_t out_data;
    int                 errors;
    int                 pending;
    int                 cycles;
    int                 ready_gap;
    bit                 ready_burst;
    bit                 long_hold;
    bit                 send_burst;

    periodic_job_scheduler_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    periodic_job_scheduler_checker checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: any hang ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_periodic_job_scheduler_top NOT OK");
            $finish;
        end
    end

    // Receiver: after most accepted results, drop ready for a drawn number of
    // cycles. In burst stretches the gap is zero so results stream back to back.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b0;
            ready_gap   <= 0;
            ready_burst <= 1'b0;
        end
        else if (long_hold)
            out_ready <= 1'b0;
        else if (ready_gap > 0)
        begin
            out_ready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end
        else if (out_valid && out_ready)
        begin
            // switch between bursty and stalling stretches now and then
            if ($urandom_range(0, 19) == 0) ready_burst <= ~ready_burst;
            if (!ready_burst && $urandom_range(0, 16) > 0)
            begin
                out_ready <= 1'b0;
                ready_gap <= $urandom_range(0, 15);
            end
            else
                out_ready <= 1'b1;
        end
        else
            out_ready <= 1'b1;
    end

    // Long receiver hold-off: the sender keeps offering, so the block fills
    // up with a pending result and must hold its input off.
    initial
    begin
        long_hold = 1'b0;
        wait (rst_n === 1'b1);
        repeat (20000) @(posedge clk);
        long_hold <= 1'b1;
        repeat (2000) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Offer one item after a drawn gap. Valid stays up between items when the
    // gap is zero, so it is never lowered and raised in the same step.
    task automatic send_item(input pjs_pkg::in_item_t it);
        int gap;
        if ($urandom_range(0, 29) == 0) send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    function automatic pjs_pkg::in_item_t make_item(input logic [1:0] cmd, input int ms,
                                                    input int sec, input int mins,
                                                    input int hrs, input int target);
        pjs_pkg::in_item_t it;
        it.cmd              = cmd;
        it.period_ms_part   = 10'(ms);
        it.period_sec_part  = 6'(sec);
        it.period_min_part  = 6'(mins);
        it.period_hour_part = 5'(hrs);
        it.target_id        = 8'(target);
        return it;
    endfunction

    // Random item: fields not used by the command still carry random bits.
    function automatic pjs_pkg::in_item_t random_item();
        pjs_pkg::in_item_t it;
        logic [63:0] raw;
        int pick;
        raw  = {$urandom, $urandom};
        it   = raw[$bits(pjs_pkg::in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 60)
            it.cmd = pjs_pkg::CMD_TICK;
        else if (pick < 82)
        begin
            it.cmd = pjs_pkg::CMD_ADD;
            // mostly short periods so jobs fire; sometimes any bit pattern
            if ($urandom_range(0, 5) != 0)
            begin
                it.period_ms_part   = 10'($urandom_range(1, 12));
                it.period_sec_part  = '0;
                it.period_min_part  = '0;
                it.period_hour_part = '0;
            end
        end
        else if (pick < 97)
        begin
            it.cmd = pjs_pkg::CMD_REMOVE;
            if ($urandom_range(0, 4) != 0) it.target_id = 8'($urandom_range(0, 70));
        end
        else
            it.cmd = pjs_pkg::CMD_CLEAR;
        return it;
    endfunction

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        send_burst = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick on an empty table, equal periods, removal, rejects.
        send_item(make_item(pjs_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        send_item(make_item(pjs_pkg::CMD_ADD, 2, 0, 0, 0, 0));
        send_item(make_item(pjs_pkg::CMD_ADD, 3, 0, 0, 0, 0));
        send_item(make_item(pjs_pkg::CMD_ADD, 3, 0, 0, 0, 0));
        repeat (5) send_item(make_item(pjs_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        send_item(make_item(pjs_pkg::CMD_REMOVE, 0, 0, 0, 0, 255));
        // drop the largest period jobs; the timer restart must follow the new max
        send_item(make_item(pjs_pkg::CMD_REMOVE, 0, 0, 0, 0, 2));
        send_item(make_item(pjs_pkg::CMD_REMOVE, 0, 0, 0, 0, 3));
        repeat (3) send_item(make_item(pjs_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        send_item(make_item(pjs_pkg::CMD_ADD, 0, 0, 0, 0, 0));
        send_item(make_item(pjs_pkg::CMD_ADD, 1023, 63, 63, 31, 0));
        send_item(make_item(pjs_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        send_item(make_item(pjs_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
        send_item(make_item(pjs_pkg::CMD_TICK, 0, 0, 0, 0, 0));
        // Fill the table with period 1 jobs, then one more add is rejected.
        repeat (17) send_item(make_item(pjs_pkg::CMD_ADD, 1, 0, 0, 0, 0));
        repeat (2) send_item(make_item(pjs_pkg::CMD_TICK, 0, 0, 0, 0, 0));

        // Random part.
        repeat (250) send_item(random_item());
        in_valid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        wait (pending == 0);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0)
            $display("tb_periodic_job_scheduler_top OK");
        else
            $display("tb_periodic_job_scheduler_top NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
